// ===== src/cagen_pkg.sv =====
`default_nettype none

package cagen_pkg;

  // Grid geometry
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int X_W         = $clog2(GRID_WIDTH);
  localparam int Y_W         = $clog2(GRID_HEIGHT);
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  // Cell and state-count ranges
  localparam int CELL_W      = 4;
  localparam int STATES_W    = 5;
  localparam int MIN_STATES  = 2;
  localparam int MAX_STATES  = 16;

  // Command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] col_x;
    logic [5:0] row_y;
    logic [3:0] cell_value;
  } req_t;

  typedef struct packed {
    logic [3:0] read_value;
    logic [1:0] done_command;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Which neighbor a grid read fetches during a generation sweep
  typedef enum logic [2:0] {
    SLOT_LEFT,
    SLOT_CENTER,
    SLOT_RIGHT,
    SLOT_UP,
    SLOT_DOWN
  } slot_t;

endpackage

`default_nettype wire

// ===== src/cyclic_automaton_generation_core.sv =====
`default_nettype none

// Cyclic cellular automaton on a toroidal GRID_WIDTH x GRID_HEIGHT grid of 4-bit cells,
// von Neumann neighborhood. One request at a time: write cell, advance one generation,
// or read cell; each gives exactly one response. Write, read and the unused code go from
// the accepting cycle in ST_IDLE through the busy state ST_DONE, where the response
// register is loaded; the response is valid in the cycle after that. A generation runs
// the sweep in ST_GEN and the bank swap in ST_DRAIN before ST_DONE. Reads are serial:
// the grid sits in a RAM with one read port, and the sweep fetches right, up and down
// neighbors for each cell (plus left and center at the start of each row), reusing the
// rest from a sliding window. The new generation goes into a second RAM bank, and the
// banks swap at the end of the sweep. A stalled response holds the block in its last
// busy cycle. The grid has no reset value; load every cell before the first read or
// generation. num_states is clamped to the range 2..16.
module cyclic_automaton_generation_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output      logic                 req_stall,
  input  wire cagen_pkg::req_t      req,
  output      logic                 rsp_valid,
  input  wire logic                 rsp_stall,
  output      cagen_pkg::rsp_t      rsp,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [4:0]           cfg_data
);

  localparam int AW = cagen_pkg::ADDR_W;
  localparam int XW = cagen_pkg::X_W;
  localparam int YW = cagen_pkg::Y_W;
  localparam int CW = cagen_pkg::CELL_W;
  localparam int SW = cagen_pkg::STATES_W;

  cagen_pkg::state_t state, state_next;
  cagen_pkg::slot_t  slot;
  cagen_pkg::slot_t  tag;

  logic [SW-1:0] num_states;
  logic [SW-1:0] k_eff;
  logic          bank;
  logic [1:0]    cmd_q;
  logic          inside_q;

  logic [XW-1:0] gx;
  logic [YW-1:0] gy;
  logic [AW-1:0] row_base;
  logic [AW-1:0] up_base;
  logic [AW-1:0] dn_base;
  logic [AW-1:0] cell_q;
  logic          tag_vld;

  logic [CW-1:0] lft;
  logic [CW-1:0] ctr;
  logic [CW-1:0] rgt;
  logic [CW-1:0] upv;

  logic          req_acc;
  logic          host_inside;
  logic [AW-1:0] host_addr;
  logic          host_we;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          gen_we;
  logic [CW-1:0] gen_val;
  logic [CW-1:0] succ;
  logic [SW-1:0] ctr_inc;
  logic          hit;
  logic          rsp_load;
  logic          row_end;
  logic          last_row;

  logic          we0, we1;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [CW-1:0] rdata0, rdata1, rdata_cur;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= SW'(cagen_pkg::MAX_STATES);
    end else if (cfg_valid) begin
      num_states <= cfg_data;
    end
  end

  // Clamp the state count into its legal range
  always_comb begin
    if (num_states < SW'(cagen_pkg::MIN_STATES)) begin
      k_eff = SW'(cagen_pkg::MIN_STATES);
    end else if (num_states > SW'(cagen_pkg::MAX_STATES)) begin
      k_eff = SW'(cagen_pkg::MAX_STATES);
    end else begin
      k_eff = num_states;
    end
  end

  // Host cell address
  assign host_inside = (int'(req.col_x) < cagen_pkg::GRID_WIDTH) &&
                       (int'(req.row_y) < cagen_pkg::GRID_HEIGHT);
  assign host_addr   = AW'(int'(req.row_y) * cagen_pkg::GRID_WIDTH + int'(req.col_x));

  assign req_acc  = req_valid && !req_stall;
  assign rsp_load = !rsp_valid || !rsp_stall;
  assign row_end  = (int'(gx) == cagen_pkg::GRID_WIDTH - 1);
  assign last_row = (int'(gy) == cagen_pkg::GRID_HEIGHT - 1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cagen_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.command == cagen_pkg::CMD_ADVANCE) ? cagen_pkg::ST_GEN
                                                               : cagen_pkg::ST_DONE;
        end
      end
      cagen_pkg::ST_GEN: begin
        if (slot == cagen_pkg::SLOT_DOWN && row_end && last_row) begin
          state_next = cagen_pkg::ST_DRAIN;
        end
      end
      cagen_pkg::ST_DRAIN: begin
        state_next = cagen_pkg::ST_DONE;
      end
      cagen_pkg::ST_DONE: begin
        if (rsp_load) begin
          state_next = cagen_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cagen_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: handshake and grid read/write port
  always_comb begin
    req_stall = 1'b1;
    host_we   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = host_addr;
    case (state)
      cagen_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        host_we   = req_valid && host_inside && (req.command == cagen_pkg::CMD_WRITE);
        rd_en     = req_valid && host_inside && (req.command == cagen_pkg::CMD_READ);
      end
      cagen_pkg::ST_GEN: begin
        rd_en = 1'b1;
        case (slot)
          cagen_pkg::SLOT_LEFT:   rd_addr = row_base + AW'(cagen_pkg::GRID_WIDTH - 1);
          cagen_pkg::SLOT_CENTER: rd_addr = row_base + AW'(gx);
          cagen_pkg::SLOT_RIGHT:  rd_addr = row_end ? row_base : row_base + AW'(gx) + 1'b1;
          cagen_pkg::SLOT_UP:     rd_addr = up_base + AW'(gx);
          cagen_pkg::SLOT_DOWN:   rd_addr = dn_base + AW'(gx);
          default:                rd_addr = row_base;
        endcase
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cagen_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request fields needed for the response
  always_ff @(posedge clk) begin
    if (req_acc) begin
      cmd_q    <= req.command;
      inside_q <= host_inside;
    end
  end

  // Sweep counters: advance through the grid row by row
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= cagen_pkg::SLOT_LEFT;
    end else if (req_acc) begin
      gx       <= '0;
      gy       <= '0;
      row_base <= '0;
      up_base  <= AW'((cagen_pkg::GRID_HEIGHT - 1) * cagen_pkg::GRID_WIDTH);
      dn_base  <= AW'(cagen_pkg::GRID_WIDTH);
      slot     <= cagen_pkg::SLOT_LEFT;
    end else if (state == cagen_pkg::ST_GEN) begin
      case (slot)
        cagen_pkg::SLOT_LEFT:   slot <= cagen_pkg::SLOT_CENTER;
        cagen_pkg::SLOT_CENTER: slot <= cagen_pkg::SLOT_RIGHT;
        cagen_pkg::SLOT_RIGHT:  slot <= cagen_pkg::SLOT_UP;
        cagen_pkg::SLOT_UP:     slot <= cagen_pkg::SLOT_DOWN;
        cagen_pkg::SLOT_DOWN: begin
          if (row_end) begin
            gx       <= '0;
            gy       <= gy + 1'b1;
            up_base  <= row_base;
            row_base <= row_base + AW'(cagen_pkg::GRID_WIDTH);
            dn_base  <= (int'(gy) == cagen_pkg::GRID_HEIGHT - 2) ? '0
                        : dn_base + AW'(cagen_pkg::GRID_WIDTH);
            slot     <= cagen_pkg::SLOT_LEFT;
          end else begin
            gx   <= gx + 1'b1;
            slot <= cagen_pkg::SLOT_RIGHT;
          end
        end
        default: slot <= cagen_pkg::SLOT_LEFT;
      endcase
    end
  end

  // Tag each issued read so its data lands in the right window register
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_vld <= 1'b0;
    end else begin
      tag_vld <= (state == cagen_pkg::ST_GEN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == cagen_pkg::ST_GEN) begin
      tag    <= slot;
      cell_q <= row_base + AW'(gx);
    end
  end

  // Capture neighbors; on the last one shift the window one cell right
  always_ff @(posedge clk) begin
    if (tag_vld) begin
      case (tag)
        cagen_pkg::SLOT_LEFT:   lft <= rdata_cur;
        cagen_pkg::SLOT_CENTER: ctr <= rdata_cur;
        cagen_pkg::SLOT_RIGHT:  rgt <= rdata_cur;
        cagen_pkg::SLOT_UP:     upv <= rdata_cur;
        cagen_pkg::SLOT_DOWN: begin
          lft <= ctr;
          ctr <= rgt;
        end
        default: upv <= rdata_cur;
      endcase
    end
  end

  // Cell update rule
  assign ctr_inc = SW'(ctr) + 1'b1;
  assign succ    = (ctr_inc < k_eff) ? ctr_inc[CW-1:0] : '0;
  assign hit     = (lft == succ) || (rgt == succ) || (upv == succ) || (rdata_cur == succ);
  assign gen_val = hit ? succ : ctr;
  assign gen_we  = tag_vld && (tag == cagen_pkg::SLOT_DOWN);

  // Bank swap at the end of a sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
    end else if (state == cagen_pkg::ST_DRAIN) begin
      bank <= ~bank;
    end
  end

  // Host writes go to the live bank, sweep results to the other one
  assign waddr = gen_we ? cell_q : host_addr;
  assign wdata = gen_we ? gen_val : req.cell_value;
  assign we0   = (host_we && !bank) || (gen_we && bank);
  assign we1   = (host_we && bank) || (gen_we && !bank);
  assign rdata_cur = bank ? rdata1 : rdata0;

  cagen_ram #(
    .WIDTH (CW),
    .DEPTH (cagen_pkg::CELL_COUNT)
  ) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en && !bank),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  cagen_ram #(
    .WIDTH (CW),
    .DEPTH (cagen_pkg::CELL_COUNT)
  ) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en && bank),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  // Response register: load when free or being taken, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == cagen_pkg::ST_DONE && rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cagen_pkg::ST_DONE && rsp_load) begin
      rsp.done_command <= cmd_q;
      rsp.read_value   <= (cmd_q == cagen_pkg::CMD_READ && inside_q) ? rdata_cur : '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/cagen_ram.sv =====
`default_nettype none

module cagen_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 4_000_000;
  localparam int         DRAIN_WAIT  = 20;

  // Track the grid and the state count, predict each response and check it in order
  class automaton_tracker;
    logic [cagen_pkg::CELL_W-1:0]   cells [cagen_pkg::CELL_COUNT];
    logic [cagen_pkg::CELL_W-1:0]   fresh [cagen_pkg::CELL_COUNT];
    logic [cagen_pkg::STATES_W-1:0] states_reg = 5'd16;
    cagen_pkg::rsp_t                pending_rsp [$];
    int                             errors = 0;

    task report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function int cycle_len();
      if (states_reg < cagen_pkg::MIN_STATES) return cagen_pkg::MIN_STATES;
      if (states_reg > cagen_pkg::MAX_STATES) return cagen_pkg::MAX_STATES;
      return int'(states_reg);
    endfunction

    function logic [cagen_pkg::CELL_W-1:0] successor(input logic [cagen_pkg::CELL_W-1:0] s);
      return (int'(s) + 1 < cycle_len()) ? s + 4'd1 : 4'd0;
    endfunction

    function void set_states(input logic [cagen_pkg::STATES_W-1:0] v);
      states_reg = v;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    // One synchronous generation over the torus, from the old grid only
    function void step_generation();
      int yu, yd, xl, xr;
      logic [cagen_pkg::CELL_W-1:0] s, succ;
      for (int y = 0; y < cagen_pkg::GRID_HEIGHT; y++) begin
        yu = (y == 0) ? cagen_pkg::GRID_HEIGHT - 1 : y - 1;
        yd = (y == cagen_pkg::GRID_HEIGHT - 1) ? 0 : y + 1;
        for (int x = 0; x < cagen_pkg::GRID_WIDTH; x++) begin
          xl = (x == 0) ? cagen_pkg::GRID_WIDTH - 1 : x - 1;
          xr = (x == cagen_pkg::GRID_WIDTH - 1) ? 0 : x + 1;
          s = cells[y * cagen_pkg::GRID_WIDTH + x];
          succ = successor(s);
          if (cells[y * cagen_pkg::GRID_WIDTH + xl] == succ ||
              cells[y * cagen_pkg::GRID_WIDTH + xr] == succ ||
              cells[yu * cagen_pkg::GRID_WIDTH + x] == succ ||
              cells[yd * cagen_pkg::GRID_WIDTH + x] == succ)
            fresh[y * cagen_pkg::GRID_WIDTH + x] = succ;
          else
            fresh[y * cagen_pkg::GRID_WIDTH + x] = s;
        end
      end
      cells = fresh;
    endfunction

    // Apply an accepted request and queue the response it must produce
    function void note_request(input cagen_pkg::req_t r);
      cagen_pkg::rsp_t exp;
      exp.read_value   = '0;
      exp.done_command = r.command;
      case (r.command)
        cagen_pkg::CMD_WRITE: begin
          cells[{r.row_y, r.col_x}] = r.cell_value;
        end
        cagen_pkg::CMD_ADVANCE: begin
          step_generation();
        end
        cagen_pkg::CMD_READ: begin
          exp.read_value = cells[{r.row_y, r.col_x}];
        end
        default: begin
        end
      endcase
      pending_rsp.push_back(exp);
    endfunction

    task check_response(input cagen_pkg::rsp_t got);
      cagen_pkg::rsp_t exp;
      if (pending_rsp.size() == 0) begin
        report($sformatf("unexpected response: read_value %0d, done_command %0d",
                         got.read_value, got.done_command));
      end else begin
        exp = pending_rsp.pop_front();
        if (got.done_command !== exp.done_command)
          report($sformatf("done_command: got %0d, expected %0d",
                           got.done_command, exp.done_command));
        if (got.read_value !== exp.read_value)
          report($sformatf("read_value: got %0d, expected %0d (command %0d)",
                           got.read_value, exp.read_value, exp.done_command));
      end
    endtask

    task check_drained();
      if (pending_rsp.size() != 0)
        report($sformatf("%0d responses never arrived", pending_rsp.size()));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           req_valid;
  logic                           req_stall;
  cagen_pkg::req_t                req;
  logic                           rsp_valid;
  logic                           rsp_stall;
  cagen_pkg::rsp_t                rsp;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cagen_pkg::STATES_W-1:0] cfg_data;

  automaton_tracker book = new;
  bit               calm = 1'b1;
  int               cycles = 0;

  cyclic_automaton_generation_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one, none while calm
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function cagen_pkg::req_t make_req(input logic [1:0] cmd, input logic [5:0] x,
                                     input logic [5:0] y, input logic [3:0] v);
    cagen_pkg::req_t r;
    r.command    = cmd;
    r.col_x      = x;
    r.row_y      = y;
    r.cell_value = v;
    return r;
  endfunction

  function logic [5:0] near(input logic [5:0] c);
    return c + 6'($urandom_range(0, 4)) - 6'd2;
  endfunction

  function logic [5:0] pick_center();
    if ($urandom_range(0, 9) < 3) return 6'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                             : $urandom_range(62, 63));
    return 6'($urandom_range(0, 63));
  endfunction

  // Monitor: check responses, then apply requests and register writes
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst) begin
      if (rsp_valid && !rsp_stall) book.check_response(rsp);
      if (req_valid && !req_stall) book.note_request(req);
      if (cfg_valid && cfg_ready) book.set_states(cfg_data);
    end
  end

  // Response back-pressure: random runs of stall and no stall
  initial begin
    int  run;
    logic level;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      level = !calm && ($urandom_range(0, 2) == 0);
      run = level ? pick_gap() + 1 : $urandom_range(1, 12);
      rsp_stall <= level;
      repeat (run - 1) @(negedge clk);
    end
  end

  // Hold one request until accepted; leave valid high so the next can follow at once
  task send_req(input cagen_pkg::req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Write the state count once all outstanding responses are back
  task write_states(input logic [cagen_pkg::STATES_W-1:0] v);
    req_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Seed a small patch with one forced transition, advance, then read around it
  task seed_and_watch(input int k);
    logic [5:0] cx, cy;
    logic [3:0] s;
    int         n;
    cx = pick_center();
    cy = pick_center();
    s = 4'($urandom_range(0, k - 1));
    send_req(make_req(cagen_pkg::CMD_WRITE, cx, cy, s));
    send_req(make_req(cagen_pkg::CMD_WRITE, cx + 6'd1, cy,
                      (int'(s) + 1 < k) ? s + 4'd1 : 4'd0));
    n = $urandom_range(0, 2);
    repeat (n)
      send_req(make_req(cagen_pkg::CMD_WRITE, near(cx), near(cy),
                        ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(0, k - 1))));
    send_req(make_req(cagen_pkg::CMD_ADVANCE, 6'($urandom), 6'($urandom), 4'($urandom)));
    send_req(make_req(cagen_pkg::CMD_READ, cx, cy, 4'($urandom)));
    n = $urandom_range(1, 3);
    repeat (n) send_req(make_req(cagen_pkg::CMD_READ, near(cx), near(cy), 4'($urandom)));
  endtask

  // Unstructured request: any command, any field values
  task send_noise();
    logic [1:0] cmd;
    cmd = ($urandom_range(0, 9) == 0) ? cagen_pkg::CMD_ADVANCE
        : ($urandom_range(0, 2) == 0) ? CMD_UNUSED
        : ($urandom_range(0, 1) == 0) ? cagen_pkg::CMD_WRITE : cagen_pkg::CMD_READ;
    send_req(make_req(cmd, 6'($urandom), 6'($urandom), 4'($urandom)));
  endtask

  task run_phase(input logic [cagen_pkg::STATES_W-1:0] states);
    int k;
    write_states(states);
    k = (states < cagen_pkg::MIN_STATES) ? cagen_pkg::MIN_STATES
      : (states > cagen_pkg::MAX_STATES) ? cagen_pkg::MAX_STATES : states;
    repeat (2) seed_and_watch(k);
    send_noise();
  endtask

  initial begin
    logic [cagen_pkg::STATES_W-1:0] phase_states [9];
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    phase_states = '{5'd2, 5'd0, 5'd5, 5'd31, 5'd1, 5'd3, 5'd17, 5'd16, 5'd4};

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_states(5'd16);

    // Load every cell before any read or generation
    for (int y = 0; y < cagen_pkg::GRID_HEIGHT; y++) begin
      if (y == 8) calm = 1'b0;
      for (int x = 0; x < cagen_pkg::GRID_WIDTH; x++)
        send_req(make_req(cagen_pkg::CMD_WRITE, 6'(x), 6'(y), 4'($urandom_range(0, 15))));
    end

    // Corners, field extremes, the unused code and wrap-around neighbors
    send_req(make_req(cagen_pkg::CMD_READ, 6'd0, 6'd0, 4'd0));
    send_req(make_req(cagen_pkg::CMD_READ, 6'd63, 6'd63, 4'd15));
    send_req(make_req(cagen_pkg::CMD_WRITE, 6'd0, 6'd0, 4'd0));
    send_req(make_req(cagen_pkg::CMD_WRITE, 6'd63, 6'd63, 4'd15));
    send_req(make_req(cagen_pkg::CMD_WRITE, 6'd63, 6'd0, 4'd15));
    send_req(make_req(cagen_pkg::CMD_WRITE, 6'd0, 6'd63, 4'd1));
    send_req(make_req(cagen_pkg::CMD_READ, 6'd0, 6'd0, 4'd15));
    send_req(make_req(cagen_pkg::CMD_READ, 6'd63, 6'd63, 4'd0));
    send_req(make_req(CMD_UNUSED, 6'd63, 6'd63, 4'd15));
    send_req(make_req(CMD_UNUSED, 6'd0, 6'd0, 4'd0));
    send_req(make_req(cagen_pkg::CMD_ADVANCE, 6'd63, 6'd63, 4'd15));
    send_req(make_req(cagen_pkg::CMD_READ, 6'd0, 6'd0, 4'd0));
    send_req(make_req(cagen_pkg::CMD_READ, 6'd63, 6'd0, 4'd0));
    send_req(make_req(cagen_pkg::CMD_READ, 6'd0, 6'd63, 4'd0));
    send_req(make_req(cagen_pkg::CMD_READ, 6'd63, 6'd63, 4'd0));

    // A stored value at or above the state count wraps to zero
    write_states(5'd3);
    send_req(make_req(cagen_pkg::CMD_WRITE, 6'd1, 6'd1, 4'd9));
    send_req(make_req(cagen_pkg::CMD_WRITE, 6'd2, 6'd1, 4'd0));
    send_req(make_req(cagen_pkg::CMD_WRITE, 6'd5, 6'd5, 4'd2));
    send_req(make_req(cagen_pkg::CMD_WRITE, 6'd5, 6'd6, 4'd0));
    send_req(make_req(cagen_pkg::CMD_ADVANCE, 6'd0, 6'd0, 4'd0));
    send_req(make_req(cagen_pkg::CMD_READ, 6'd1, 6'd1, 4'd0));
    send_req(make_req(cagen_pkg::CMD_READ, 6'd5, 6'd5, 4'd0));

    for (int p = 0; p < 9; p++) begin
      calm = (p == 3);
      run_phase(phase_states[p]);
    end
    calm = 1'b0;

    // Read back a scattered sample of cells after the last generation
    repeat (32)
      send_req(make_req(cagen_pkg::CMD_READ, 6'($urandom), 6'($urandom), 4'($urandom)));

    req_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    book.check_drained();
    if (book.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
